/* hdl/ttb_pkg.sv */
// Shared types and constants of the triangle tangent basis core.
// Holds the vertex, job and result item layouts and the datapath widths.
// Depends on nothing; every other file imports it.
package ttb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// difference of two coordinates, product of two differences, difference of products
	localparam int DW     = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DW;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = PROD_W;
	localparam int REM_W  = MAG_W + 1;
	localparam int DCNT_W = $clog2(COORD_WIDTH + 1);

	localparam int QDEPTH = 2;
	localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QC_W   = $clog2(QDEPTH + 1);

	localparam int TERMS     = 7;
	localparam int MUL_STEPS = 2 * TERMS;
	localparam int MCNT_W    = $clog2(MUL_STEPS);
	localparam int TI_W      = MCNT_W - 1;
	localparam int TERM_DET  = 0;
	localparam int TERM_TAN  = 1;
	localparam int TERM_BIT  = 4;
	localparam int DIV_LANES = TERMS - 1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_LAST  = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] tex_u;
		logic signed [COORD_WIDTH-1:0] tex_v;
	} ttb_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] tangent_x;
		logic signed [COORD_WIDTH-1:0] tangent_y;
		logic signed [COORD_WIDTH-1:0] tangent_z;
		logic signed [COORD_WIDTH-1:0] bitangent_x;
		logic signed [COORD_WIDTH-1:0] bitangent_y;
		logic signed [COORD_WIDTH-1:0] bitangent_z;
		logic [1:0]                    corner;
		logic                          degenerate;
		logic                          last;
	} ttb_out_t;

	// one unit of work for the back end: a lone vertex or a whole triangle
	typedef struct packed {
		logic                 is_tri;
		logic signed [DW-1:0] e1x;
		logic signed [DW-1:0] e1y;
		logic signed [DW-1:0] e1z;
		logic signed [DW-1:0] e2x;
		logic signed [DW-1:0] e2y;
		logic signed [DW-1:0] e2z;
		logic signed [DW-1:0] du1;
		logic signed [DW-1:0] dv1;
		logic signed [DW-1:0] du2;
		logic signed [DW-1:0] dv2;
	} ttb_job_t;

endpackage

/* hdl/triangle_tangent_basis_core.sv */
// Top level of the triangle tangent basis core.
// Ties the front end, the job queue and the back end together.
// Depends on ttb_pkg, ttb_front, ttb_queue and ttb_back.

// Vertices come in one per item on the input channel. In triangle mode the first
// two corners are held and the third completes the triangle: the block then gives
// three results, one per corner, each with the saturated Q16.16 tangent and
// bitangent and a degenerate flag for a zero UV determinant. With triangle mode off
// each vertex gives one result with zero vectors. The front end takes a vertex
// every cycle until its two-entry job queue is full; for a triangle the back end
// makes 14 passes through its one shared 33x33 multiplier, then runs the six
// bit-serial divider lanes unless the UV determinant is zero, then emits one
// result per corner; a lone vertex goes straight to its single result. Write the
// mode register only when no results are pending.
module triangle_tangent_basis_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  ttb_pkg::ttb_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output ttb_pkg::ttb_out_t out_item
);
	import ttb_pkg::*;

	logic     q_full;
	logic     q_push;
	ttb_job_t q_push_job;
	logic     job_valid;
	ttb_job_t job;
	logic     job_take;

	ttb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_push_job)
	);

	ttb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.job_valid (job_valid),
		.job       (job),
		.pop       (job_take)
	);

	ttb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* hdl/ttb_front.sv */
// Front end: mode register, vertex intake, corner holding and edge/UV deltas.
// Pushes one job per lone vertex or per completed triangle into the job queue.
// Depends on ttb_pkg.
module ttb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  ttb_pkg::ttb_in_t  in_item,
	input  logic              q_full,
	output logic              q_push,
	output ttb_pkg::ttb_job_t q_job
);
	import ttb_pkg::*;

	logic                          tri_mode_q;
	logic [1:0]                    corner_q;
	logic signed [COORD_WIDTH-1:0] hpos_q [2][3];
	logic signed [COORD_WIDTH-1:0] huv_q  [2][2];
	logic                          accept;
	logic                          hold;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	// corner count of three behaves like two and closes the triangle
	assign hold     = accept && tri_mode_q && !corner_q[1];
	assign q_push   = accept && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_mode_q <= 1'b1;
			corner_q   <= CORNER_FIRST;
		end else begin
			if (cfg_we) begin
				tri_mode_q <= cfg_wdata;
			end
			if (hold) begin
				corner_q <= {1'b0, corner_q[0]} + 2'd1;
			end else if (accept) begin
				corner_q <= CORNER_FIRST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold) begin
			hpos_q[corner_q[0]][0] <= in_item.pos_x;
			hpos_q[corner_q[0]][1] <= in_item.pos_y;
			hpos_q[corner_q[0]][2] <= in_item.pos_z;
			huv_q[corner_q[0]][0]  <= in_item.tex_u;
			huv_q[corner_q[0]][1]  <= in_item.tex_v;
		end
	end

	always_comb begin
		q_job.is_tri = tri_mode_q;
		q_job.e1x    = DW'(hpos_q[1][0]) - DW'(hpos_q[0][0]);
		q_job.e1y    = DW'(hpos_q[1][1]) - DW'(hpos_q[0][1]);
		q_job.e1z    = DW'(hpos_q[1][2]) - DW'(hpos_q[0][2]);
		q_job.e2x    = DW'(in_item.pos_x) - DW'(hpos_q[0][0]);
		q_job.e2y    = DW'(in_item.pos_y) - DW'(hpos_q[0][1]);
		q_job.e2z    = DW'(in_item.pos_z) - DW'(hpos_q[0][2]);
		q_job.du1    = DW'(huv_q[1][0]) - DW'(huv_q[0][0]);
		q_job.dv1    = DW'(huv_q[1][1]) - DW'(huv_q[0][1]);
		q_job.du2    = DW'(in_item.tex_u) - DW'(huv_q[0][0]);
		q_job.dv2    = DW'(in_item.tex_v) - DW'(huv_q[0][1]);
	end

endmodule

/* hdl/ttb_queue.sv */
// Short job queue between the front end and the back end.
// Register array with read and write pointers and an occupancy count.
// Depends on ttb_pkg.
module ttb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ttb_pkg::ttb_job_t push_job,
	output logic              full,
	output logic              job_valid,
	output ttb_pkg::ttb_job_t job,
	input  logic              pop
);
	import ttb_pkg::*;

	ttb_job_t        slot_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	assign full      = (count_q == QC_W'(QDEPTH));
	assign job_valid = (count_q != '0);
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QC_W'(QDEPTH)) || pop)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("job queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QC_W'(QDEPTH))
		else $error("job queue count past depth");
`endif

endmodule

/* hdl/ttb_div.sv */
// One lane of the basis divider: (num << FRAC_BITS) / den, truncated and saturated.
// Restoring division, one quotient bit per cycle, for a COORD_WIDTH-bit quotient.
// Depends on ttb_pkg.
module ttb_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ttb_pkg::SUM_W-1:0]    num,
	input  logic signed [ttb_pkg::SUM_W-1:0]    den,
	output logic                                done,
	output logic signed [ttb_pkg::COORD_WIDTH-1:0] quo
);
	import ttb_pkg::*;

	logic [SUM_W-1:0]           num_abs;
	logic [SUM_W-1:0]           den_abs;
	logic [MAG_W+FRAC_BITS-1:0] num_sh;
	logic [REM_W-1:0]           rem_init;
	logic [REM_W-1:0]           den_ext;
	logic [REM_W-1:0]           rem_sh;
	logic                       ge;
	logic [COORD_WIDTH-1:0]     lim;
	logic [COORD_WIDTH-1:0]     q_sat;

	logic                       run_q;
	logic                       done_q;
	logic [DCNT_W-1:0]          cnt_q;
	logic [REM_W-1:0]           rem_q;
	logic [MAG_W-1:0]           den_q;
	logic [COORD_WIDTH-1:0]     low_q;
	logic [COORD_WIDTH-1:0]     quo_q;
	logic                       ovf_q;
	logic                       neg_q;

	assign num_abs  = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign den_abs  = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
	assign num_sh   = {num_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
	// upper part seeds the remainder; it reaching den means the quotient needs more bits
	assign rem_init = REM_W'(num_sh[MAG_W+FRAC_BITS-1:COORD_WIDTH]);
	assign den_ext  = {1'b0, den_abs[MAG_W-1:0]};

	assign rem_sh = {rem_q[REM_W-2:0], low_q[COORD_WIDTH-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(COORD_WIDTH);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den_abs[MAG_W-1:0];
			low_q <= num_sh[COORD_WIDTH-1:0];
			quo_q <= '0;
			ovf_q <= rem_init >= den_ext;
			neg_q <= num[SUM_W-1] ^ den[SUM_W-1];
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			low_q <= {low_q[COORD_WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[COORD_WIDTH-2:0], ge};
		end
	end

	// negative results may reach one step further than positive ones
	assign lim   = neg_q ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
	assign q_sat = (ovf_q || quo_q > lim) ? lim : quo_q;
	assign quo   = neg_q ? -q_sat : q_sat;
	assign done  = done_q;

endmodule

/* hdl/ttb_back.sv */
// Back end: per-job sequencer with a shared 33x33 multiplier, six divider lanes
// and the result register. Emits one result per lone vertex, three per triangle.
// Depends on ttb_pkg and ttb_div.
module ttb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  ttb_pkg::ttb_job_t job,
	output logic              job_take,
	output logic              out_valid,
	input  logic              out_stall,
	output ttb_pkg::ttb_out_t out_item
);
	import ttb_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_MULW,
		B_DIVGO,
		B_DIV,
		B_EMIT
	} bst_t;

	bst_t                         state_q;
	logic [MCNT_W-1:0]            mul_cnt_q;
	logic [1:0]                   corner_q;
	logic                         degen_q;
	logic                         out_valid_q;
	ttb_out_t                     out_q;
	ttb_job_t                     job_q;

	logic                         pval_s1;
	logic [MCNT_W-1:0]            ptag_s1;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [PROD_W-1:0]     first_q;
	logic signed [SUM_W-1:0]      term_q [TERMS];

	logic [TI_W-1:0]              mterm;
	logic [1:0]                   axis;
	logic signed [DW-1:0]         e1_sel;
	logic signed [DW-1:0]         e2_sel;
	logic signed [DW-1:0]         op_a;
	logic signed [DW-1:0]         op_b;
	logic                         det_zero;
	logic                         div_start;
	logic [DIV_LANES-1:0]         div_done;
	logic signed [COORD_WIDTH-1:0] quo [DIV_LANES];
	logic                         out_free;
	logic                         emit_last;
	logic                         vec_on;

	assign job_take  = (state_q == B_IDLE) && job_valid;
	assign det_zero  = (term_q[TERM_DET] == '0);
	assign div_start = (state_q == B_DIVGO) && !det_zero;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = !job_q.is_tri || (corner_q == CORNER_LAST);
	assign vec_on    = job_q.is_tri && !degen_q;

	// operand select: even steps give the first product of a term, odd steps the second
	assign mterm = mul_cnt_q[MCNT_W-1:1];

	always_comb begin
		if (mterm >= TI_W'(TERM_BIT)) begin
			axis = 2'(mterm - TI_W'(TERM_BIT));
		end else begin
			axis = 2'(mterm - TI_W'(TERM_TAN));
		end
		case (axis)
			AXIS_X: begin
				e1_sel = job_q.e1x;
				e2_sel = job_q.e2x;
			end
			AXIS_Y: begin
				e1_sel = job_q.e1y;
				e2_sel = job_q.e2y;
			end
			AXIS_Z: begin
				e1_sel = job_q.e1z;
				e2_sel = job_q.e2z;
			end
			default: begin
				e1_sel = '0;
				e2_sel = '0;
			end
		endcase
		if (mterm == TI_W'(TERM_DET)) begin
			op_a = mul_cnt_q[0] ? job_q.du2 : job_q.du1;
			op_b = mul_cnt_q[0] ? job_q.dv1 : job_q.dv2;
		end else if (mterm < TI_W'(TERM_BIT)) begin
			op_a = mul_cnt_q[0] ? e2_sel : e1_sel;
			op_b = mul_cnt_q[0] ? job_q.dv1 : job_q.dv2;
		end else begin
			op_a = mul_cnt_q[0] ? e1_sel : e2_sel;
			op_b = mul_cnt_q[0] ? job_q.du2 : job_q.du1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		ptag_s1 <= mul_cnt_q;
		if (pval_s1) begin
			if (!ptag_s1[0]) begin
				first_q <= prod_s1;
			end else begin
				term_q[ptag_s1[MCNT_W-1:1]] <= SUM_W'(first_q) - SUM_W'(prod_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			mul_cnt_q   <= '0;
			corner_q    <= CORNER_FIRST;
			degen_q     <= 1'b0;
			pval_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			pval_s1 <= (state_q == B_MUL);
			if (out_free) begin
				out_valid_q <= (state_q == B_EMIT);
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q   <= job.is_tri ? B_MUL : B_EMIT;
						mul_cnt_q <= '0;
						corner_q  <= CORNER_FIRST;
					end
				end
				B_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == MCNT_W'(MUL_STEPS - 1)) begin
						state_q <= B_MULW;
					end
				end
				B_MULW: begin
					// last term lands at this edge
					state_q <= B_DIVGO;
				end
				B_DIVGO: begin
					degen_q <= det_zero;
					state_q <= det_zero ? B_EMIT : B_DIV;
				end
				B_DIV: begin
					if (div_done[0]) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_q.tangent_x   <= vec_on ? quo[0] : '0;
						out_q.tangent_y   <= vec_on ? quo[1] : '0;
						out_q.tangent_z   <= vec_on ? quo[2] : '0;
						out_q.bitangent_x <= vec_on ? quo[3] : '0;
						out_q.bitangent_y <= vec_on ? quo[4] : '0;
						out_q.bitangent_z <= vec_on ? quo[5] : '0;
						out_q.corner      <= corner_q;
						out_q.degenerate  <= job_q.is_tri && degen_q;
						out_q.last        <= emit_last;
						corner_q          <= corner_q + 2'd1;
						if (emit_last) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
		ttb_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (term_q[l + 1]),
			.den    (term_q[TERM_DET]),
			.done   (div_done[l]),
			.quo    (quo[l])
		);
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(div_done) == 0) || ($countones(div_done) == DIV_LANES))
		else $error("divider lanes out of step");
	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_done[0])
		else $error("divider done survived a start");
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> (out_q.corner != CORNER_LAST))
		else $error("non-final result on the closing corner");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.degenerate) |->
		(out_q.tangent_x == '0) && (out_q.tangent_y == '0) && (out_q.tangent_z == '0) &&
		(out_q.bitangent_x == '0) && (out_q.bitangent_y == '0) &&
		(out_q.bitangent_z == '0))
		else $error("degenerate result with nonzero vectors");
`endif

endmodule
